[rtl/wtg_pkg.sv]
// shared types, constants and helpers of the waveform trajectory generator
// no dependencies; imported by wtg_ctrl, wtg_dp and waveform_trajectory_generator
package wtg_pkg;

    localparam int DEFAULT_SINE_TABLE_DEPTH = 1024;
    localparam int DEFAULT_FRACTION_BITS    = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FORM     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SLEW     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_KP       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_KD       = 3'd7;

    // waveform forms
    localparam logic [2:0] FORM_USER   = 3'd0;
    localparam logic [2:0] FORM_STEP   = 3'd1;
    localparam logic [2:0] FORM_SINE   = 3'd2;
    localparam logic [2:0] FORM_SQUARE = 3'd3;
    localparam logic [2:0] FORM_TRI    = 3'd4;

    localparam logic PROTO_SERVO = 1'b0;
    localparam logic PROTO_MIT   = 1'b1;

    localparam logic [1:0] CHAN_POSITION = 2'd0;
    localparam logic [1:0] CHAN_VELOCITY = 2'd1;

    localparam logic [31:0] TICK_RESET = 32'd4294967;
    localparam logic [16:0] SLEW_RESET = 17'd435;
    localparam logic [16:0] SLEW_ONE   = 17'd65536;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic [32:0]     TWO_PI_Q30  = 33'd6746518852;
    localparam longint          Q30_ONE     = 64'sd1073741824;

    // shared multiplier
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // datapath step codes
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_SLEW_A = 4'd1;
    localparam logic [3:0] OP_SLEW_F = 4'd2;
    localparam logic [3:0] OP_APPLY  = 4'd3;
    localparam logic [3:0] OP_PH_MUL = 4'd4;
    localparam logic [3:0] OP_PH_ADD = 4'd5;
    localparam logic [3:0] OP_IDX    = 4'd6;
    localparam logic [3:0] OP_ROM    = 4'd7;
    localparam logic [3:0] OP_VAL    = 4'd8;
    localparam logic [3:0] OP_M      = 4'd9;
    localparam logic [3:0] OP_K      = 4'd10;
    localparam logic [3:0] OP_HI     = 4'd11;
    localparam logic [3:0] OP_LO     = 4'd12;
    localparam logic [3:0] OP_DER    = 4'd13;

    typedef struct packed {
        logic       capture;
        logic [3:0] op;
        logic       load_out;
    } wtg_cmd_t;

    typedef struct packed {
        logic out_free;
    } wtg_status_t;

    // saturate a sign and magnitude to signed 32 bits
    function automatic logic signed [31:0] sat_s32(input logic neg, input logic [63:0] mag);
        logic signed [31:0] r;
        if (neg)
            r = (mag > 64'd2147483648) ? 32'sh80000000 : 32'(-mag);
        else
            r = (mag > 64'd2147483647) ? 32'sh7fffffff : 32'(mag);
        return r;
    endfunction

endpackage

[rtl/wtg_ctrl.sv]
// sequencer of the waveform trajectory generator: walks one tick through the datapath
// depends on wtg_pkg
module wtg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wtg_pkg::wtg_status_t status,
    output wtg_pkg::wtg_cmd_t    cmd
);
    import wtg_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SLEW_A = 4'd1;
    localparam logic [3:0] ST_SLEW_F = 4'd2;
    localparam logic [3:0] ST_APPLY  = 4'd3;
    localparam logic [3:0] ST_PH_MUL = 4'd4;
    localparam logic [3:0] ST_PH_ADD = 4'd5;
    localparam logic [3:0] ST_IDX    = 4'd6;
    localparam logic [3:0] ST_ROM    = 4'd7;
    localparam logic [3:0] ST_VAL    = 4'd8;
    localparam logic [3:0] ST_M      = 4'd9;
    localparam logic [3:0] ST_K      = 4'd10;
    localparam logic [3:0] ST_HI     = 4'd11;
    localparam logic [3:0] ST_LO     = 4'd12;
    localparam logic [3:0] ST_DER    = 4'd13;
    localparam logic [3:0] ST_DONE   = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        cmd.op       = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SLEW_A;
                end
            end
            ST_SLEW_A: begin cmd.op = OP_SLEW_A; state_next = ST_SLEW_F; end
            ST_SLEW_F: begin cmd.op = OP_SLEW_F; state_next = ST_APPLY;  end
            ST_APPLY:  begin cmd.op = OP_APPLY;  state_next = ST_PH_MUL; end
            ST_PH_MUL: begin cmd.op = OP_PH_MUL; state_next = ST_PH_ADD; end
            ST_PH_ADD: begin cmd.op = OP_PH_ADD; state_next = ST_IDX;    end
            ST_IDX:    begin cmd.op = OP_IDX;    state_next = ST_ROM;    end
            ST_ROM:    begin cmd.op = OP_ROM;    state_next = ST_VAL;    end
            ST_VAL:    begin cmd.op = OP_VAL;    state_next = ST_M;      end
            ST_M:      begin cmd.op = OP_M;      state_next = ST_K;      end
            ST_K:      begin cmd.op = OP_K;      state_next = ST_HI;     end
            ST_HI:     begin cmd.op = OP_HI;     state_next = ST_LO;     end
            ST_LO:     begin cmd.op = OP_LO;     state_next = ST_DER;    end
            ST_DER:    begin cmd.op = OP_DER;    state_next = ST_DONE;   end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/wtg_dp.sv]
// datapath of the waveform trajectory generator: registers, shared multiplier, sine rom
// depends on wtg_pkg; driven by wtg_ctrl commands
module wtg_dp #(
    parameter int SINE_TABLE_DEPTH = wtg_pkg::DEFAULT_SINE_TABLE_DEPTH,
    parameter int FRACTION_BITS    = wtg_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wtg_pkg::wtg_cmd_t                    cmd,
    output wtg_pkg::wtg_status_t                 status,
    input  logic                                 cfg_write,
    input  logic [wtg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [wtg_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [31:0]                   target_amplitude,
    input  logic [31:0]                          target_frequency,
    input  logic signed [31:0]                   user_target,
    input  logic signed [31:0]                   step_position,
    input  logic signed [31:0]                   step_velocity,
    input  logic signed [31:0]                   step_torque,
    input  logic [31:0]                          step_position_gain,
    input  logic [31:0]                          step_velocity_gain,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           primary_type,
    output logic signed [31:0]                   primary,
    output logic signed [31:0]                   position,
    output logic signed [31:0]                   velocity,
    output logic signed [31:0]                   torque,
    output logic [31:0]                          position_gain_out,
    output logic [31:0]                          velocity_gain_out
);
    import wtg_pkg::*;

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);

    typedef logic [30:0] rom_t [0:SINE_TABLE_DEPTH];

    // unsigned quotient by restoring division, used only while building the rom
    function automatic longint unsigned quot_u64(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter-wave sine in Q1.30 by integer taylor series
    function automatic rom_t build_rom();
        rom_t                r;
        longint unsigned     x;
        longint unsigned     x2;
        longint unsigned     term;
        longint unsigned     den;
        longint              sum;
        int                  i;
        int                  k;
        for (i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x    = quot_u64(HALF_PI_Q30 * 64'(i), 64'(SINE_TABLE_DEPTH));
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (k = 1; k < 40; k++)
            begin
                den  = 64'((2 * k) * (2 * k + 1));
                term = quot_u64((term * x2) >> 30, den);
                if (k[0])
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > Q30_ONE)
                sum = Q30_ONE;
            r[i] = 31'(sum);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // configuration
    logic [2:0]  form_reg;
    logic        proto_reg;
    logic [1:0]  chan_reg;
    logic        deriv_reg;
    logic [31:0] tick_reg;
    logic [16:0] slew_reg;
    logic [31:0] kp_reg;
    logic [31:0] kd_reg;

    // captured transaction
    logic signed [31:0] t_amp_reg;
    logic [31:0]        t_freq_reg;
    logic signed [31:0] user_reg;
    logic signed [31:0] spos_reg;
    logic signed [31:0] svel_reg;
    logic signed [31:0] stor_reg;
    logic [31:0]        skp_reg;
    logic [31:0]        skd_reg;

    // trajectory state
    logic signed [31:0] amp_reg;
    logic [31:0]        freq_reg;
    logic [31:0]        phase_reg;
    logic               primed_reg;

    // working registers
    logic [PROD_W-1:0]  prod_reg;
    logic [30:0]        rom_a_reg;
    logic [30:0]        rom_b_reg;
    logic signed [31:0] val_reg;
    logic [63:0]        m_reg;
    logic [MUL_W-1:0]   k_reg;
    logic [63:0]        hi_reg;
    logic signed [31:0] der_reg;
    logic               out_valid_reg;

    logic [1:0]         primary_type_reg;
    logic signed [31:0] primary_reg;
    logic signed [31:0] position_reg;
    logic signed [31:0] velocity_reg;
    logic signed [31:0] torque_reg;
    logic [31:0]        kp_out_reg;
    logic [31:0]        kd_out_reg;

    logic [16:0]        gain;
    logic signed [32:0] rem_a;
    logic signed [32:0] rem_f;
    logic [32:0]        mrem_a;
    logic [32:0]        mrem_f;
    logic [PROD_W-1:0]  rnd;
    logic [33:0]        md;
    logic               slew_hold;
    logic [33:0]        amp_step;
    logic [33:0]        freq_step;
    logic [1:0]         quad;
    logic [1:0]         cquad;
    logic [30:0]        s_mag;
    logic               s_neg;
    logic [30:0]        c_mag;
    logic               c_neg;
    logic signed [32:0] tri_s;
    logic [30:0]        tri_mag;
    logic               tri_neg;
    logic [30:0]        fac_mag;
    logic               fac_neg;
    logic               amp_neg;
    logic [31:0]        amp_mag;
    logic [AW-1:0]      idx;
    logic [AW-1:0]      idx_b;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [63:0]        scale_mag;
    logic signed [31:0] val_next;
    logic [63:0]        der_mag;
    logic               up;
    logic signed [31:0] der_next;
    logic               take;

    // slew
    assign gain   = (slew_reg > SLEW_ONE) ? SLEW_ONE : slew_reg;
    assign rem_a  = 33'(t_amp_reg) - 33'(amp_reg);
    assign rem_f  = $signed({1'b0, t_freq_reg}) - $signed({1'b0, freq_reg});
    assign mrem_a = rem_a[32] ? 33'(-rem_a) : 33'(rem_a);
    assign mrem_f = rem_f[32] ? 33'(-rem_f) : 33'(rem_f);
    assign rnd    = prod_reg + PROD_W'(32768);
    assign md     = rnd[49:16];
    assign slew_hold = (md == 34'd0) || (tick_reg == 32'd0);
    assign amp_step  = rem_a[32] ? (34'(amp_reg) - md) : (34'(amp_reg) + md);
    assign freq_step = rem_f[32] ? ({2'b00, freq_reg} - md) : ({2'b00, freq_reg} + md);

    // waveform factors
    assign quad    = phase_reg[31:30];
    assign cquad   = quad + 2'd1;
    assign s_mag   = quad[0] ? rom_b_reg : rom_a_reg;
    assign s_neg   = quad[1] && (s_mag != 31'd0);
    assign c_mag   = cquad[0] ? rom_b_reg : rom_a_reg;
    assign c_neg   = cquad[1] && (c_mag != 31'd0);

    always_comb
    begin
        if (quad == 2'd0)
            tri_s = $signed({1'b0, phase_reg});
        else if (phase_reg < 32'hc0000000)
            tri_s = 33'sh080000000 - $signed({1'b0, phase_reg});
        else
            tri_s = $signed({1'b0, phase_reg}) - 33'sh100000000;
    end

    assign tri_neg = tri_s[32];
    assign tri_mag = tri_neg ? 31'(-tri_s) : 31'(tri_s);
    assign fac_mag = (form_reg == FORM_TRI) ? tri_mag : s_mag;
    assign fac_neg = (form_reg == FORM_TRI) ? tri_neg : s_neg;
    assign amp_neg = amp_reg[31];
    assign amp_mag = amp_neg ? (~amp_reg + 32'd1) : amp_reg;

    assign idx   = prod_reg[30 +: AW];
    assign idx_b = AW'(SINE_TABLE_DEPTH) - idx;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SLEW_A: begin mul_a = MUL_W'(mrem_a); mul_b = MUL_W'(gain); end
            OP_SLEW_F: begin mul_a = MUL_W'(mrem_f); mul_b = MUL_W'(gain); end
            OP_PH_MUL: begin mul_a = MUL_W'(freq_reg); mul_b = MUL_W'(tick_reg); end
            OP_IDX:    begin mul_a = MUL_W'(phase_reg[29:0]); mul_b = MUL_W'(SINE_TABLE_DEPTH); end
            OP_VAL:    begin mul_a = MUL_W'(amp_mag); mul_b = MUL_W'(fac_mag); end
            OP_M:      begin mul_a = MUL_W'(amp_mag); mul_b = MUL_W'(freq_reg); end
            OP_K:      begin mul_a = MUL_W'(TWO_PI_Q30); mul_b = MUL_W'(c_mag); end
            OP_HI:     begin mul_a = MUL_W'(m_reg[63:30]); mul_b = MUL_W'(prod_reg >> 30); end
            OP_LO:     begin mul_a = MUL_W'(m_reg[29:0]); mul_b = k_reg; end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // waveform value from the scaled product
    assign scale_mag = 64'((prod_reg + PROD_W'(32'h20000000)) >> 30);

    always_comb
    begin
        case (form_reg)
            FORM_USER:   val_next = user_reg;
            FORM_STEP:   val_next = spos_reg;
            FORM_SINE:   val_next = sat_s32(amp_neg != fac_neg, scale_mag);
            FORM_SQUARE: val_next = !phase_reg[31] ? amp_reg
                                  : sat_s32(!amp_neg && (amp_reg != 32'sd0), 64'(amp_mag));
            FORM_TRI:    val_next = sat_s32(amp_neg != fac_neg, scale_mag);
            default:     val_next = '0;
        endcase
    end

    // analytic derivative
    assign der_mag = hi_reg + 64'(prod_reg >> 30);
    assign up      = (quad == 2'd0) || (quad == 2'd3);

    always_comb
    begin
        case (form_reg)
            FORM_SINE: der_next = sat_s32(amp_neg != c_neg, der_mag);
            FORM_TRI:  der_next = sat_s32(amp_neg != !up, m_reg << 2);
            default:   der_next = '0;
        endcase
    end

    assign take            = out_valid_reg && out_ready;
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            form_reg      <= FORM_USER;
            proto_reg     <= PROTO_SERVO;
            chan_reg      <= CHAN_POSITION;
            deriv_reg     <= 1'b0;
            tick_reg      <= TICK_RESET;
            slew_reg      <= SLEW_RESET;
            kp_reg        <= '0;
            kd_reg        <= '0;
            amp_reg       <= '0;
            freq_reg      <= '0;
            phase_reg     <= '0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FORM:     form_reg  <= cfg_data[2:0];
                    REG_PROTOCOL: proto_reg <= cfg_data[0];
                    REG_CHANNEL:  chan_reg  <= cfg_data[1:0];
                    REG_DERIV:    deriv_reg <= cfg_data[0];
                    REG_TICK:     tick_reg  <= cfg_data;
                    REG_SLEW:     slew_reg  <= cfg_data[16:0];
                    REG_KP:       kp_reg    <= cfg_data;
                    REG_KD:       kd_reg    <= cfg_data;
                    default:      ;
                endcase
            end

            if (cmd.op == OP_SLEW_F)
                amp_reg <= (!primed_reg || slew_hold) ? t_amp_reg : 32'(amp_step);
            if (cmd.op == OP_APPLY)
            begin
                freq_reg   <= (!primed_reg || slew_hold) ? t_freq_reg : 32'(freq_step);
                primed_reg <= 1'b1;
            end
            if ((cmd.op == OP_PH_ADD) && (tick_reg != 32'd0))
                phase_reg <= phase_reg + 32'(prod_reg >> FRACTION_BITS);

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (take)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (cmd.capture)
        begin
            t_amp_reg  <= target_amplitude;
            t_freq_reg <= target_frequency;
            user_reg   <= user_target;
            spos_reg   <= step_position;
            svel_reg   <= step_velocity;
            stor_reg   <= step_torque;
            skp_reg    <= step_position_gain;
            skd_reg    <= step_velocity_gain;
        end

        if (cmd.op == OP_ROM)
        begin
            rom_a_reg <= SINE_ROM[idx];
            rom_b_reg <= SINE_ROM[idx_b];
        end
        if (cmd.op == OP_M)
            val_reg <= val_next;
        if (cmd.op == OP_K)
            m_reg <= 64'(prod_reg >> FRACTION_BITS);
        if (cmd.op == OP_HI)
            k_reg <= MUL_W'(prod_reg >> 30);
        if (cmd.op == OP_LO)
            hi_reg <= 64'(prod_reg);
        if (cmd.op == OP_DER)
            der_reg <= der_next;

        if (cmd.load_out)
        begin
            if ((proto_reg == PROTO_MIT) && (form_reg == FORM_STEP))
            begin
                primary_type_reg <= CHAN_POSITION;
                primary_reg      <= spos_reg;
                position_reg     <= spos_reg;
                velocity_reg     <= svel_reg;
                torque_reg       <= stor_reg;
                kp_out_reg       <= skp_reg;
                kd_out_reg       <= skd_reg;
            end
            else
            begin
                primary_type_reg <= chan_reg;
                primary_reg      <= val_reg;
                kp_out_reg       <= (proto_reg == PROTO_MIT) ? kp_reg : 32'd0;
                kd_out_reg       <= (proto_reg == PROTO_MIT) ? kd_reg : 32'd0;
                position_reg     <= (chan_reg == CHAN_POSITION) ? val_reg : 32'sd0;
                torque_reg       <= chan_reg[1] ? val_reg : 32'sd0;
                if (chan_reg == CHAN_VELOCITY)
                    velocity_reg <= val_reg;
                else if ((chan_reg == CHAN_POSITION) && (proto_reg == PROTO_MIT) && deriv_reg)
                    velocity_reg <= der_reg;
                else
                    velocity_reg <= 32'sd0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign primary_type      = primary_type_reg;
    assign primary           = primary_reg;
    assign position          = position_reg;
    assign velocity          = velocity_reg;
    assign torque            = torque_reg;
    assign position_gain_out = kp_out_reg;
    assign velocity_gain_out = kd_out_reg;

endmodule

[rtl/waveform_trajectory_generator.sv]
// an accepted input transaction walks the datapath steps in turn, then waits until the
//   output register is free; no new transaction is taken before that, as one shared 34x34
//   multiplier computes nine products in turn (slew, phase, sine index, value, derivative)
// a finished result waits in the output register while the next transaction is taken
// reset: rst_n asynchronous active low clears configuration to defaults, the running
//   amplitude, frequency and phase to zero, and the first-tick flag
module waveform_trajectory_generator #(
    parameter int SINE_TABLE_DEPTH = wtg_pkg::DEFAULT_SINE_TABLE_DEPTH,
    parameter int FRACTION_BITS    = wtg_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write,
    input  logic [wtg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wtg_pkg::CFG_DATA_W-1:0]   cfg_data,
    // tick input channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [31:0]               target_amplitude,
    input  logic [31:0]                      target_frequency,
    input  logic signed [31:0]               user_target,
    input  logic signed [31:0]               step_position,
    input  logic signed [31:0]               step_velocity,
    input  logic signed [31:0]               step_torque,
    input  logic [31:0]                      step_position_gain,
    input  logic [31:0]                      step_velocity_gain,
    // command output channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       primary_type,
    output logic signed [31:0]               primary,
    output logic signed [31:0]               position,
    output logic signed [31:0]               velocity,
    output logic signed [31:0]               torque,
    output logic [31:0]                      position_gain_out,
    output logic [31:0]                      velocity_gain_out
);
    import wtg_pkg::*;

    // control and status between sequencer and datapath
    wtg_cmd_t    cmd;
    wtg_status_t status;

    // sequencer: idle until a transaction arrives, then steps the datapath
    // and parks until the output register can take the result
    wtg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: slew, phase accumulator, sine rom, value and derivative, routing
    wtg_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .target_amplitude   (target_amplitude),
        .target_frequency   (target_frequency),
        .user_target        (user_target),
        .step_position      (step_position),
        .step_velocity      (step_velocity),
        .step_torque        (step_torque),
        .step_position_gain (step_position_gain),
        .step_velocity_gain (step_velocity_gain),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .primary_type       (primary_type),
        .primary            (primary),
        .position           (position),
        .velocity           (velocity),
        .torque             (torque),
        .position_gain_out  (position_gain_out),
        .velocity_gain_out  (velocity_gain_out)
    );

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// self-checking bench for waveform_trajectory_generator: directed and random ticks
// against an in-bench predictor; depends on rtl/wtg_pkg.sv and the block's rtl
module testbench;
    import wtg_pkg::*;

    // channel codes the package leaves out
    localparam logic [1:0] CHAN_TORQUE  = 2'd2;
    localparam logic [1:0] CHAN_VOLTAGE = 2'd3;
    // highest form code; 5..7 are unused codes
    localparam logic [2:0] FORM_SPARE   = 3'd7;

    localparam int                SINE_DEPTH = 1024;
    localparam longint unsigned   HALF_PI_Q = 64'd1686629713;
    localparam longint unsigned   TWO_PI_Q  = 64'd6746518852;
    localparam longint            ONE_Q30   = 64'sd1073741824;
    localparam int                HOLD_CYCLES = 300;

    typedef struct packed {
        logic [31:0] amplitude;
        logic [31:0] frequency;
        logic [31:0] user;
        logic [31:0] step_pos;
        logic [31:0] step_vel;
        logic [31:0] step_tor;
        logic [31:0] step_kp;
        logic [31:0] step_kd;
    } tick_t;

    typedef struct packed {
        logic [1:0]  ptype;
        logic [31:0] prim;
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] tor;
        logic [31:0] kp;
        logic [31:0] kd;
    } command_t;

    typedef struct packed {
        logic [2:0]  form;
        logic        proto;
        logic [1:0]  chan;
        logic        deriv;
        logic [31:0] tick;
        logic [16:0] slew;
        logic [31:0] kp;
        logic [31:0] kd;
    } settings_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] target_amplitude = '0;
    logic [31:0] target_frequency = '0;
    logic signed [31:0] user_target = '0;
    logic signed [31:0] step_position = '0;
    logic signed [31:0] step_velocity = '0;
    logic signed [31:0] step_torque = '0;
    logic [31:0] step_position_gain = '0;
    logic [31:0] step_velocity_gain = '0;
    logic out_valid;
    logic out_ready = 1'b1;
    logic [1:0] primary_type;
    logic signed [31:0] primary, position, velocity, torque;
    logic [31:0] position_gain_out, velocity_gain_out;

    waveform_trajectory_generator u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .target_amplitude(target_amplitude), .target_frequency(target_frequency),
        .user_target(user_target), .step_position(step_position),
        .step_velocity(step_velocity), .step_torque(step_torque),
        .step_position_gain(step_position_gain), .step_velocity_gain(step_velocity_gain),
        .out_valid(out_valid), .out_ready(out_ready),
        .primary_type(primary_type), .primary(primary), .position(position),
        .velocity(velocity), .torque(torque),
        .position_gain_out(position_gain_out), .velocity_gain_out(velocity_gain_out)
    );

    always #1 clk = ~clk;

    // predictor copy of the configuration and the running state
    settings_t   cur;
    longint      amp_now;
    logic [31:0] freq_now;
    logic [31:0] phase_now;
    bit          primed;
    logic [31:0] sine_tab [0:SINE_DEPTH];

    command_t pending_commands[$];
    int errors = 0;
    int ticks_sent = 0;
    int commands_seen = 0;
    int phases_run = 0;
    bit no_gaps = 1'b0;
    bit hold_go = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    // quarter-wave table by the integer taylor series, clamped to [0, 1.0]
    function automatic void build_sine_table();
        longint unsigned x, x2, term, k;
        longint sum;
        for (int i = 0; i <= SINE_DEPTH; i++)
        begin
            x = HALF_PI_Q * 64'(i) / 64'(SINE_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (k = 1; k < 40 && term != 0; k++)
            begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k[0])
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > ONE_Q30)
                sum = ONE_Q30;
            sine_tab[i] = sum[31:0];
        end
    endfunction

    function automatic longint unsigned mag_of(longint v);
        return (v < 0) ? unsigned'(-v) : unsigned'(v);
    endfunction

    function automatic longint clamp_s32(bit neg, longint unsigned mag);
        if (neg)
            return (mag > 64'd2147483648) ? -64'sd2147483648 : -longint'(mag);
        return (mag > 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
    endfunction

    function automatic longint sine_lookup(logic [31:0] p);
        logic [9:0] idx;
        longint s;
        idx = p[29:20];
        s = p[30] ? longint'({32'b0, sine_tab[SINE_DEPTH - idx]})
                  : longint'({32'b0, sine_tab[idx]});
        return p[31] ? -s : s;
    endfunction

    function automatic longint scale_by(longint amp, longint factor);
        longint unsigned mag;
        mag = (mag_of(amp) * mag_of(factor) + (64'd1 << 29)) >> 30;
        return clamp_s32((amp < 0) != (factor < 0), mag);
    endfunction

    // first-order lag step; snaps when the rounded step is zero or time stands still
    function automatic longint slew_step(longint now, longint target);
        longint rem;
        longint unsigned g, md;
        rem = target - now;
        g = (cur.slew > SLEW_ONE) ? 64'd65536 : 64'(cur.slew);
        md = (mag_of(rem) * g + 64'd32768) >> 16;
        if (md == 0 || cur.tick == 0)
            return target;
        return (rem < 0) ? now - longint'(md) : now + longint'(md);
    endfunction

    function automatic longint wave_level(tick_t t);
        longint tri_lvl;
        case (cur.form)
            FORM_USER:   return longint'(signed'(t.user));
            FORM_STEP:   return longint'(signed'(t.step_pos));
            FORM_SINE:   return scale_by(amp_now, sine_lookup(phase_now));
            FORM_SQUARE: return (phase_now < 32'h80000000) ? amp_now
                                : clamp_s32(amp_now > 0, mag_of(amp_now));
            FORM_TRI:
            begin
                if (phase_now < 32'h40000000)
                    tri_lvl = longint'({32'b0, phase_now});
                else if (phase_now < 32'hC0000000)
                    tri_lvl = 64'sd2147483648 - longint'({32'b0, phase_now});
                else
                    tri_lvl = longint'({32'b0, phase_now}) - 64'sd4294967296;
                return scale_by(amp_now, tri_lvl);
            end
            default:     return 0;
        endcase
    endfunction

    function automatic longint wave_slope();
        longint unsigned m, k, mag;
        longint c;
        logic [31:0] pc;
        bit up;
        m = (mag_of(amp_now) * {32'b0, freq_now}) >> 16;
        if (cur.form == FORM_SINE)
        begin
            pc = phase_now + 32'h40000000;
            c = sine_lookup(pc);
            k = (TWO_PI_Q * mag_of(c)) >> 30;
            mag = (m >> 30) * k + (((m & 64'h3FFFFFFF) * k) >> 30);
            return clamp_s32((amp_now < 0) != (c < 0), mag);
        end
        if (cur.form == FORM_TRI)
        begin
            up = (phase_now < 32'h40000000) || (phase_now >= 32'hC0000000);
            return clamp_s32((amp_now < 0) != !up, m * 4);
        end
        return 0;
    endfunction

    // advance the predictor by one tick and build the expected command
    function automatic command_t predict_command(tick_t t);
        command_t c;
        longint level, nf;
        logic [63:0] adv;
        c = '0;
        if (!primed)
        begin
            amp_now = longint'(signed'(t.amplitude));
            freq_now = t.frequency;
            primed = 1'b1;
        end
        else
        begin
            amp_now = slew_step(amp_now, longint'(signed'(t.amplitude)));
            nf = slew_step(longint'({32'b0, freq_now}), longint'({32'b0, t.frequency}));
            freq_now = nf[31:0];
        end
        if (cur.tick != 0)
        begin
            adv = {32'b0, freq_now} * {32'b0, cur.tick};
            phase_now = phase_now + adv[47:16];
        end
        if (cur.proto == PROTO_MIT && cur.form == FORM_STEP)
        begin
            // mit step form passes the step setpoints and gains straight through
            c.ptype = CHAN_POSITION;
            c.prim = t.step_pos;
            c.pos = t.step_pos;
            c.vel = t.step_vel;
            c.tor = t.step_tor;
            c.kp = t.step_kp;
            c.kd = t.step_kd;
        end
        else
        begin
            level = wave_level(t);
            c.ptype = cur.chan;
            c.prim = level[31:0];
            if (cur.proto == PROTO_MIT)
            begin
                c.kp = cur.kp;
                c.kd = cur.kd;
            end
            if (cur.chan == CHAN_POSITION)
            begin
                c.pos = level[31:0];
                if (cur.proto == PROTO_MIT && cur.deriv)
                begin
                    level = wave_slope();
                    c.vel = level[31:0];
                end
            end
            else if (cur.chan == CHAN_VELOCITY)
                c.vel = level[31:0];
            else
                c.tor = level[31:0];
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t on command %0d: %s got %h want %h",
                 $realtime, commands_seen, what, got, want);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one tick transaction, keep valid up across back-to-back items
    task automatic send_tick(tick_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        target_amplitude <= t.amplitude;
        target_frequency <= t.frequency;
        user_target <= t.user;
        step_position <= t.step_pos;
        step_velocity <= t.step_vel;
        step_torque <= t.step_tor;
        step_position_gain <= t.step_kp;
        step_velocity_gain <= t.step_kd;
        in_valid <= 1'b1;
        pending_commands.push_back(predict_command(t));
        ticks_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop valid and let the block drain before touching registers
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_commands.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // write all eight registers, one per cycle, then release the port
    task automatic apply_settings(settings_t s);
        logic [31:0] vals [8];
        vals[REG_FORM] = {29'b0, s.form};
        vals[REG_PROTOCOL] = {31'b0, s.proto};
        vals[REG_CHANNEL] = {30'b0, s.chan};
        vals[REG_DERIV] = {31'b0, s.deriv};
        vals[REG_TICK] = s.tick;
        vals[REG_SLEW] = {15'b0, s.slew};
        vals[REG_KP] = s.kp;
        vals[REG_KD] = s.kd;
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[CFG_INDEX_W-1:0];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cur = s;
        phases_run++;
    endtask

    function automatic settings_t default_settings();
        settings_t s;
        s = '0;
        s.form = FORM_USER;
        s.tick = TICK_RESET;
        s.slew = SLEW_RESET;
        return s;
    endfunction

    function automatic logic [31:0] pick_signed();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'h0;
            3: return 32'hFFFFFFFF;
            4, 5, 6, 7: return $urandom;
            default: return $urandom_range(0, 32'h001FFFFF) - 32'h00100000;
        endcase
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int r;
        t.amplitude = pick_signed();
        r = $urandom_range(0, 15);
        if (r == 0)
            t.frequency = 32'hFFFFFFFF;
        else if (r == 1)
            t.frequency = 32'h0;
        else if (r < 5)
            t.frequency = $urandom;
        else
            t.frequency = $urandom_range(0, 32'h03FFFFFF);
        t.user = pick_signed();
        t.step_pos = pick_signed();
        t.step_vel = pick_signed();
        t.step_tor = pick_signed();
        t.step_kp = $urandom;
        t.step_kd = $urandom;
        return t;
    endfunction

    function automatic settings_t random_settings();
        settings_t s;
        int r;
        r = $urandom_range(0, 19);
        s.form = (r < 2) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        s.proto = 1'($urandom_range(0, 1));
        s.chan = 2'($urandom_range(0, 3));
        s.deriv = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 19);
        if (r == 0)
            s.tick = 32'h0;
        else if (r == 1)
            s.tick = 32'hFFFFFFFF;
        else if (r < 9)
            s.tick = TICK_RESET;
        else if (r < 15)
            s.tick = $urandom_range(1, 32'h03FFFFFF);
        else
            s.tick = $urandom;
        r = $urandom_range(0, 11);
        case (r)
            0: s.slew = 17'd0;
            1: s.slew = SLEW_ONE;
            2: s.slew = 17'h1FFFF;
            3: s.slew = SLEW_RESET;
            4: s.slew = 17'($urandom_range(65537, 131071));
            default: s.slew = 17'($urandom_range(0, 65536));
        endcase
        s.kp = $urandom;
        s.kd = $urandom;
        return s;
    endfunction

    // receiver: random ready with short and long stalls, plus one long hold-off
    always @(posedge clk)
    begin
        int r;
        if (hold_go && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (no_gaps)
            out_ready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                stall_left <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    // checker: each output transaction against the oldest expected command
    always @(posedge clk)
    begin
        command_t want;
        if (rst_n && out_valid && out_ready)
        begin
            commands_seen++;
            if (pending_commands.size() == 0)
            begin
                $display("unexpected command at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = pending_commands.pop_front();
                if (primary_type != want.ptype)
                    report_mismatch("primary_type", {30'b0, primary_type}, {30'b0, want.ptype});
                if (primary != want.prim)
                    report_mismatch("primary", primary, want.prim);
                if (position != want.pos)
                    report_mismatch("position", position, want.pos);
                if (velocity != want.vel)
                    report_mismatch("velocity", velocity, want.vel);
                if (torque != want.tor)
                    report_mismatch("torque", torque, want.tor);
                if (position_gain_out != want.kp)
                    report_mismatch("position_gain_out", position_gain_out, want.kp);
                if (velocity_gain_out != want.kd)
                    report_mismatch("velocity_gain_out", velocity_gain_out, want.kd);
            end
        end
    end

    // first tick after reset loads targets directly, at the field extremes
    task automatic test_first_tick();
        tick_t t;
        t = '0;
        t.amplitude = 32'h80000000;
        t.frequency = 32'hFFFFFFFF;
        t.user = 32'h7FFFFFFF;
        send_tick(t);
        t.amplitude = 32'h7FFFFFFF;
        t.frequency = 32'h0;
        t.user = 32'h80000000;
        send_tick(t);
        wait_drained();
    endtask

    // every form code, including the unused ones, in mit position mode with slope
    task automatic test_each_form();
        settings_t s;
        tick_t t;
        for (int f = 0; f <= FORM_SPARE; f++)
        begin
            s = default_settings();
            s.form = f[2:0];
            s.proto = PROTO_MIT;
            s.chan = CHAN_POSITION;
            s.deriv = 1'b1;
            s.tick = 32'h01000000;
            s.slew = SLEW_ONE;
            s.kp = 32'hFFFFFFFF;
            s.kd = 32'h00010000;
            apply_settings(s);
            t = random_tick();
            t.frequency = 32'h00050000;
            send_tick(t);
            t.amplitude = 32'h80000000;
            send_tick(t);
            wait_drained();
        end
    endtask

    // servo routing to each channel, zero tick, zero and oversize slew gain
    task automatic test_routing_and_slew();
        settings_t s;
        s = default_settings();
        s.form = FORM_SINE;
        s.tick = 32'h02000000;
        for (int ch = 0; ch < 4; ch++)
        begin
            s.chan = ch[1:0];
            apply_settings(s);
            send_tick(random_tick());
            wait_drained();
        end
        s.chan = CHAN_VOLTAGE;
        s.form = FORM_TRI;
        s.tick = 32'h0;
        apply_settings(s);
        send_tick(random_tick());
        send_tick(random_tick());
        wait_drained();
        s.tick = 32'hFFFFFFFF;
        s.chan = CHAN_TORQUE;
        s.slew = 17'd0;
        apply_settings(s);
        send_tick(random_tick());
        wait_drained();
        s.slew = 17'h1FFFF;
        apply_settings(s);
        send_tick(random_tick());
        wait_drained();
    endtask

    // random settings per phase, random ticks with every gap pattern
    task automatic test_random_phases();
        for (int ph = 0; ph < 40; ph++)
        begin
            no_gaps = (ph % 5 == 0);
            apply_settings(random_settings());
            for (int n = 0; n < 40; n++)
                send_tick(random_tick());
            wait_drained();
        end
        no_gaps = 1'b0;
    endtask

    // receiver holds off for a long stretch while ticks keep coming
    task automatic test_backpressure();
        settings_t s;
        s = default_settings();
        s.form = FORM_SINE;
        s.proto = PROTO_MIT;
        s.deriv = 1'b1;
        s.tick = 32'h00800000;
        apply_settings(s);
        no_gaps = 1'b1;
        hold_go <= 1'b1;
        for (int n = 0; n < 16; n++)
            send_tick(random_tick());
        no_gaps = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        build_sine_table();
        cur = default_settings();
        amp_now = 0;
        freq_now = '0;
        phase_now = '0;
        primed = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_first_tick();
        test_each_form();
        test_routing_and_slew();
        test_random_phases();
        test_backpressure();
        $display("covered %0d ticks and %0d commands over %0d register settings",
                 ticks_sent, commands_seen, phases_run);
        $display("all forms, both protocols, all channels, slew and phase extremes, long stall");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #2000000;
        $display("timeout with %0d commands still expected", pending_commands.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
